// ===== rtl/oflc_pkg.sv =====
// Shared types, codes and level-geometry helpers for the octree free-leaf counter.
package oflc_pkg;

  // Fixed field widths of the item interface.
  localparam int FuncW  = 2;
  localparam int IdxW   = 10;
  localparam int SlotW  = 3;
  localparam int IdxSpan = 1 << IdxW;

  // Function codes carried by an input item.
  localparam logic [FuncW-1:0] FuncRead   = 2'd0;
  localparam logic [FuncW-1:0] FuncRemove = 2'd1;
  localparam logic [FuncW-1:0] FuncChild  = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IdxW-1:0]  node_index;
    logic [SlotW-1:0] child_slot;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] value;
    logic            ok;
  } out_item_t;

  // Commands broadcast from the sequencer to every level cell.
  typedef struct packed {
    logic load;    // take the item's node index
    logic shift;   // take the parent of the level below
    logic rd_en;   // read the held node's count
    logic wr_en;   // write back the count less one
    logic clr_en;  // write the reset count during the clearing pass
  } ctrl_t;

  // Index of the first node on a level (root level 0).
  function automatic int lvl_start(input int lvl);
    int s;
    int p;
    s = 0;
    p = 1;
    for (int l = 0; l < lvl; l++) begin
      s = s + p;
      p = p * 8;
    end
    return s;
  endfunction

  // Number of nodes of a level that a 10-bit index can reach (at least one).
  function automatic int lvl_size(input int lvl);
    int full;
    int reach;
    full  = 1 << (3 * lvl);
    reach = IdxSpan - lvl_start(lvl);
    if (reach < 1) begin
      reach = 1;
    end
    return (full < reach) ? full : reach;
  endfunction

  // Largest level store over a tree of the given depth.
  function automatic int max_size(input int depth);
    int m;
    m = 1;
    for (int l = 0; l < depth; l++) begin
      if (lvl_size(l) > m) begin
        m = lvl_size(l);
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/octree_free_leaf_counter_top.sv =====
// Child index and bad functions are decoded straight into the result; a count read reads the
// level stores. A removal walks the leaf's path up the row of level cells one level per cycle,
// then does one read on every level store at once and, if the whole path is non-zero, one
// write-back; one item is in flight at a time. A finished item waits in an output register
// while the next item is taken. After reset a clearing pass over the largest level store
// (512 addresses at DEPTH 4) loads each store with its leaf count; the input stalls until done.
module octree_free_leaf_counter_top #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  oflc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output oflc_pkg::out_item_t out_item_o
);
  import oflc_pkg::*;

  localparam int NodeCount = lvl_start(DEPTH);
  localparam int LeafFirst = lvl_start(DEPTH - 1);
  localparam int CntW      = 3 * (DEPTH - 1) + 1;
  localparam int MaxSize   = max_size(DEPTH);
  localparam int ClrW      = $clog2(MaxSize);
  localparam int ShW       = $clog2(DEPTH);
  localparam int ChildW    = IdxW + 4;

  // Sequencer states.
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StShift = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StEval  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [ShW-1:0]  cnt_q, cnt_d;
  logic [ClrW-1:0] clr_q, clr_d;
  in_item_t        req_q, req_d;
  out_item_t       res_q, res_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  ctrl_t           ctrl;
  logic            accept;
  logic            is_leaf;
  logic [ChildW-1:0] child;
  logic            child_ok;

  logic [IdxW-1:0] parent [DEPTH];
  logic            ok_chain [DEPTH+1];
  logic [CntW-1:0] val_chain [DEPTH+1];

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // Decode of the incoming item.
  assign is_leaf  = (int'(in_item_i.node_index) >= LeafFirst) &&
                    (int'(in_item_i.node_index) < NodeCount);
  assign child    = {in_item_i.node_index, 3'b000} + ChildW'(in_item_i.child_slot)
                    + ChildW'(1);
  assign child_ok = int'(child) < NodeCount;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    ctrl        = '0;
    case (state_q)
      StClear: begin
        ctrl.clr_en = 1'b1;
        clr_d       = clr_q + ClrW'(1);
        if (int'(clr_q) == MaxSize - 1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          req_d     = in_item_i;
          ctrl.load = 1'b1;
          res_d     = '0;
          case (in_item_i.func)
            FuncRead: begin
              state_d = StRead;
            end
            FuncRemove: begin
              if (is_leaf) begin
                cnt_d   = ShW'(DEPTH - 1);
                state_d = StShift;
              end else begin
                state_d = StDone;
              end
            end
            FuncChild: begin
              res_d.ok    = child_ok;
              res_d.value = child_ok ? IdxW'(child) : '0;
              state_d     = StDone;
            end
            default: begin
              state_d = StDone;
            end
          endcase
        end
      end
      StShift: begin
        ctrl.shift = 1'b1;
        cnt_d      = cnt_q - ShW'(1);
        if (cnt_q == ShW'(1)) begin
          state_d = StRead;
        end
      end
      StRead: begin
        ctrl.rd_en = 1'b1;
        state_d    = StEval;
      end
      StEval: begin
        if (req_q.func == FuncRead) begin
          res_d.value = IdxW'(val_chain[0]);
          res_d.ok    = int'(req_q.node_index) < NodeCount;
        end else begin
          ctrl.wr_en  = ok_chain[0];
          res_d.value = '0;
          res_d.ok    = ok_chain[0];
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Row of level cells, the leaf level at the bottom of the chain.
  assign ok_chain[DEPTH]  = 1'b1;
  assign val_chain[DEPTH] = '0;

  for (genvar l = 0; l < DEPTH; l++) begin : g_lvl
    logic [IdxW-1:0] below_idx;

    if (l == DEPTH - 1) begin : g_leaf
      assign below_idx = req_q.node_index;
    end else begin : g_inner
      assign below_idx = parent[l+1];
    end

    oflc_cell #(
      .Start (lvl_start(l)),
      .Size  (lvl_size(l)),
      .Init  (1 << (3 * (DEPTH - 1 - l))),
      .CntW  (CntW),
      .ClrW  (ClrW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .item_idx_i  (in_item_i.node_index),
      .child_idx_i (below_idx),
      .parent_o    (parent[l]),
      .clr_addr_i  (clr_q),
      .ok_i        (ok_chain[l+1]),
      .ok_o        (ok_chain[l]),
      .val_i       (val_chain[l+1]),
      .val_o       (val_chain[l])
    );
  end

endmodule

// ===== rtl/oflc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module oflc_ram #(
  parameter int Width = 10,
  parameter int Depth = 512
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/oflc_cell.sv =====
// One level of the octree: its count store, the node it holds and its link in the chain.
module oflc_cell #(
  parameter int Start = 0,
  parameter int Size  = 1,
  parameter int Init  = 1,
  parameter int CntW  = 10,
  parameter int ClrW  = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  oflc_pkg::ctrl_t          ctrl_i,
  input  logic [oflc_pkg::IdxW-1:0] item_idx_i,
  input  logic [oflc_pkg::IdxW-1:0] child_idx_i,
  output logic [oflc_pkg::IdxW-1:0] parent_o,
  input  logic [ClrW-1:0]          clr_addr_i,
  input  logic                     ok_i,
  output logic                     ok_o,
  input  logic [CntW-1:0]          val_i,
  output logic [CntW-1:0]          val_o
);
  import oflc_pkg::*;

  localparam int AddrW = (Size > 1) ? $clog2(Size) : 1;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             hit_q, hit_d;
  logic             hit;
  logic [AddrW-1:0] local_addr;
  logic [AddrW-1:0] clr_local;
  logic             clr_hit;
  logic [CntW-1:0]  rdata;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [CntW-1:0]  wdata;

  // Node held by this level: loaded from the item or taken from the level below.
  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.load) begin
      idx_d = item_idx_i;
    end else if (ctrl_i.shift) begin
      idx_d = child_idx_i;
    end
  end

  // The parent handed upwards; meaningless at the root, where it is not used.
  assign parent_o = (idx_q - IdxW'(1)) >> 3;

  // Does the held node belong to this level's store?
  assign hit        = (int'(idx_q) >= Start) && (int'(idx_q) < Start + Size);
  assign local_addr = AddrW'(int'(idx_q) - Start);
  assign clr_hit    = int'(clr_addr_i) < Size;
  assign clr_local  = AddrW'(clr_addr_i);

  assign hit_d = ctrl_i.rd_en ? hit : hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      hit_q <= hit_d;
    end
  end

  // Write side: the clearing pass loads the reset count, a removal writes count less one.
  always_comb begin
    we    = 1'b0;
    waddr = local_addr;
    wdata = rdata - CntW'(1);
    if (ctrl_i.clr_en) begin
      we    = clr_hit;
      waddr = clr_local;
      wdata = CntW'(Init);
    end else if (ctrl_i.wr_en) begin
      we = hit_q;
    end
  end

  oflc_ram #(
    .Width (CntW),
    .Depth (Size)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd_en & hit),
    .raddr_i (local_addr),
    .rdata_o (rdata)
  );

  // Chain links: the path is good only if every level hit a non-zero count.
  assign ok_o  = ok_i & hit_q & (rdata != '0);
  assign val_o = val_i | (hit_q ? rdata : '0);

endmodule

// ===== tb/tb_octree_free_leaf_counter_top.sv =====
// Self-checking testbench for the octree free-leaf counter: directed, random, back-pressure and drain tests.
`timescale 1ns / 1ps

module tb_octree_free_leaf_counter_top;
  import oflc_pkg::*;

  // Tree geometry for the depth under test.
  localparam int TreeDepth = 4;
  localparam int NodeCount = ((1 << (3 * TreeDepth)) - 1) / 7;
  localparam int LeafCount = 1 << (3 * (TreeDepth - 1));
  localparam int LeafFirst = NodeCount - LeafCount;

  // Function code that the block does not implement.
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  localparam int LongHold    = 400;
  localparam int SettleLimit = 40;
  localparam int CycleLimit  = 900000;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Free-leaf counts as the block should hold them, and answers still to arrive.
  logic [IdxW-1:0] free_left [NodeCount];
  out_item_t       expected_answers [$];

  bit failed = 1'b0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_trigger = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  octree_free_leaf_counter_top #(
    .DEPTH(TreeDepth)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o)
  );

  always #4 clk = ~clk;

  // Every node starts with the number of leaves beneath it.
  function automatic void reset_counts();
    int lvl_first;
    int lvl_nodes;
    int per_node;
    lvl_first = 0;
    lvl_nodes = 1;
    per_node  = LeafCount;
    for (int lvl = 0; lvl < TreeDepth; lvl++) begin
      for (int k = 0; k < lvl_nodes; k++) begin
        free_left[lvl_first + k] = per_node[IdxW-1:0];
      end
      lvl_first += lvl_nodes;
      lvl_nodes *= 8;
      per_node  /= 8;
    end
  endfunction

  // Works out the answer to one item and applies any removal to the counts.
  function automatic out_item_t predict_answer(input in_item_t item);
    out_item_t ans;
    int idx;
    int node;
    int child;
    bit good;
    bit walking;
    ans = '0;
    idx = int'(item.node_index);
    case (item.func)
      FuncRead: begin
        if (idx < NodeCount) begin
          ans.value = free_left[idx];
          ans.ok    = 1'b1;
        end
      end
      FuncRemove: begin
        // The whole path must be non-zero before anything is decremented.
        good    = (idx >= LeafFirst) && (idx < NodeCount);
        node    = idx;
        walking = good;
        while (walking) begin
          if (free_left[node] == '0) begin
            good    = 1'b0;
            walking = 1'b0;
          end else if (node == 0) begin
            walking = 1'b0;
          end else begin
            node = (node - 1) / 8;
          end
        end
        node    = idx;
        walking = good;
        while (walking) begin
          free_left[node] = free_left[node] - 1'b1;
          if (node == 0) begin
            walking = 1'b0;
          end else begin
            node = (node - 1) / 8;
          end
        end
        ans.ok = good;
      end
      FuncChild: begin
        child = 8 * idx + 1 + int'(item.child_slot);
        if (child < NodeCount) begin
          ans.value = child[IdxW-1:0];
          ans.ok    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic in_item_t make_item(input logic [FuncW-1:0] func, input int idx,
                                         input int slot);
    in_item_t item;
    item.func       = func;
    item.node_index = idx[IdxW-1:0];
    item.child_slot = slot[SlotW-1:0];
    return item;
  endfunction

  // Sender gaps: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 50);
  endfunction

  // A random item: mostly removals and reads of valid nodes, the rest noise.
  function automatic in_item_t random_item();
    int r;
    int slot;
    r    = $urandom_range(0, 99);
    slot = $urandom_range(0, 7);
    if (r < 40) begin
      // Half of the removals hit the first subtree so that used leaves turn up.
      if ($urandom_range(0, 1) == 1) begin
        return make_item(FuncRemove, LeafFirst + $urandom_range(0, 63), slot);
      end
      return make_item(FuncRemove, LeafFirst + $urandom_range(0, LeafCount - 1), slot);
    end else if (r < 70) begin
      return make_item(FuncRead, $urandom_range(0, NodeCount - 1), slot);
    end else if (r < 88) begin
      return make_item(FuncChild, $urandom_range(0, LeafFirst), slot);
    end else if (r < 94) begin
      return make_item(FuncUnused, $urandom_range(0, (1 << IdxW) - 1), slot);
    end
    return make_item(FuncW'($urandom_range(0, 2)), $urandom_range(0, (1 << IdxW) - 1),
                     slot);
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after acceptance.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall_o) begin
      @(posedge clk);
    end
    expected_answers.push_back(predict_answer(item));
    @(negedge clk);
  endtask

  // Extremes of every field and each special case.
  task automatic test_directed();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_item(make_item(FuncRead, 0, 0));
    send_item(make_item(FuncRead, NodeCount - 1, 7));
    send_item(make_item(FuncRead, NodeCount, 0));
    send_item(make_item(FuncRead, (1 << IdxW) - 1, 7));
    send_item(make_item(FuncRead, LeafFirst - 1, 0));
    send_item(make_item(FuncRemove, LeafFirst, 0));
    send_item(make_item(FuncRead, 0, 0));
    send_item(make_item(FuncRead, 9, 0));
    send_item(make_item(FuncRead, 1, 0));
    send_item(make_item(FuncRemove, LeafFirst, 5));
    send_item(make_item(FuncRemove, NodeCount - 1, 0));
    send_item(make_item(FuncRemove, LeafFirst - 1, 0));
    send_item(make_item(FuncRemove, 0, 0));
    send_item(make_item(FuncRemove, NodeCount, 0));
    send_item(make_item(FuncRemove, (1 << IdxW) - 1, 7));
    send_item(make_item(FuncChild, 0, 0));
    send_item(make_item(FuncChild, 0, 7));
    send_item(make_item(FuncChild, LeafFirst - 1, 7));
    send_item(make_item(FuncChild, LeafFirst, 0));
    send_item(make_item(FuncChild, (1 << IdxW) - 1, 7));
    send_item(make_item(FuncUnused, 5, 3));
    send_item(make_item(FuncUnused, (1 << IdxW) - 1, 7));
    send_item(make_item(FuncRead, NodeCount - 1, 0));
  endtask

  // Random mix, with idling switched on and off in stretches.
  task automatic test_random_mix(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      send_item(random_item());
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    send_idle    = 1'b0;
    recv_idle    = 1'b1;
    hold_trigger = ~hold_trigger;
    for (int n = 0; n < 40; n++) begin
      send_item(random_item());
    end
  endtask

  // Remove every leaf in random order, then check that the tree is empty.
  task automatic test_drain();
    int leaves [LeafCount];
    int j;
    int tmp;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int k = 0; k < LeafCount; k++) begin
      leaves[k] = LeafFirst + k;
    end
    for (int k = LeafCount - 1; k > 0; k--) begin
      j         = $urandom_range(0, k);
      tmp       = leaves[k];
      leaves[k] = leaves[j];
      leaves[j] = tmp;
    end
    for (int k = 0; k < LeafCount; k++) begin
      send_item(make_item(FuncRemove, leaves[k], $urandom_range(0, 7)));
      if (k % 4 == 0) begin
        send_item(make_item(FuncRead, $urandom_range(0, LeafFirst - 1), 0));
      end
    end
    send_item(make_item(FuncRead, 0, 0));
    for (int n = 0; n < 30; n++) begin
      send_item(make_item(FuncRemove, LeafFirst + $urandom_range(0, LeafCount - 1), 0));
      send_item(make_item(FuncRead, $urandom_range(0, NodeCount - 1), 0));
    end
  endtask

  // Receiver: random stalls in bursts, plus the long hold when one is requested.
  always @(negedge clk) begin : rx_side
    int r;
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_idle) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        hold_left <= $urandom_range(15, 60);
        out_stall <= 1'b1;
      end else if (r < 25) begin
        hold_left <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each accepted result is compared with the oldest expected answer.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("result with no item outstanding: value %0d ok %0d",
               out_item_o.value, out_item_o.ok);
        failed = 1'b1;
      end else begin
        want = expected_answers.pop_front();
        if (out_item_o.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_item_o.value);
          failed = 1'b1;
        end
        if (out_item_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_item_o.ok);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_counts();
    repeat (7) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_mix(1000);
    test_backpressure();
    test_drain();
    test_random_mix(150);
    in_valid <= 1'b0;

    // Wait for every answer, then allow stray results time to show.
    while (expected_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleLimit) @(posedge clk);
    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

endmodule
